[rtl/core/length_prefixed_frame_header_parser_assert.svh]
// Assertion macros shared by the frame header parser modules.
`ifndef LENGTH_PREFIXED_FRAME_HEADER_PARSER_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define LPFHP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define LPFHP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lpfhp_pkg.sv]
// Shared types for the length-prefixed frame header parser.
`timescale 1ns / 1ps

package lpfhp_pkg;

    typedef enum logic [6:0] {
        PH_SIZE    = 7'b0000001,
        PH_KEY     = 7'b0000010,
        PH_VER     = 7'b0000100,
        PH_CORR    = 7'b0001000,
        PH_IDLEN   = 7'b0010000,
        PH_ID      = 7'b0100000,
        PH_PAYLOAD = 7'b1000000
    } phase_t;

    typedef enum logic [1:0] {
        OUT_NONE  = 2'd0,
        OUT_VALID = 2'd1,
        OUT_BAD   = 2'd2
    } outcome_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] frame_offset;
        logic [31:0] frame_size;
        logic [15:0] request_key;
        logic [15:0] request_version;
        logic [31:0] corr_id;
        logic [14:0] client_id_length;
        logic [30:0] payload_length;
    } result_t;

    localparam logic [15:0] CLIENT_HDR_BASE = 16'd10;
    localparam logic [15:0] SERVER_HDR_LEN  = 16'd4;

endpackage

[rtl/core/lpfhp_parser.sv]
// Byte-wise frame header parser: state registers and per-word next-state logic.
`timescale 1ns / 1ps

module lpfhp_parser (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    input  logic                   source_is_client,
    output logic                   res_valid,
    output lpfhp_pkg::result_t     res
);

    `include "length_prefixed_frame_header_parser_assert.svh"

    lpfhp_pkg::phase_t   phase_reg, phase_next;
    logic [1:0]          fbc_reg, fbc_next;
    logic [31:0]         offset_reg, offset_next;
    logic                halted_reg, halted_next;
    logic [31:0]         start_reg, start_next;
    logic [31:0]         size_reg, size_next;
    logic [15:0]         key_reg, key_next;
    logic [15:0]         ver_reg, ver_next;
    logic [31:0]         corr_reg, corr_next;
    logic [15:0]         idl_reg, idl_next;
    logic [31:0]         rem_reg, rem_next;
    logic [15:0]         hlen_reg, hlen_next;

    logic                fresh;
    logic [31:0]         size_w;
    logic [15:0]         idl_w;
    logic [15:0]         idl_upd;
    logic [14:0]         fin_idl;
    logic [15:0]         fin_hlen;
    logic                fin_bad;
    logic                fin_zero;
    logic [31:0]         fin_rem;
    logic [31:0]         rem_dec;
    logic [15:0]         idl_out;
    logic [31:0]         pay_out;
    lpfhp_pkg::outcome_t outcome;
    logic                do_finish;

    // Header completion terms, from the id length as it stands after this word.
    always_comb begin
        fresh    = (phase_reg == lpfhp_pkg::PH_SIZE) && (fbc_reg == 2'd0);
        size_w   = fresh ? 32'd0 : size_reg;
        idl_w    = fresh ? 16'd0 : idl_reg;
        idl_upd  = (phase_reg == lpfhp_pkg::PH_IDLEN) ? {idl_w[7:0], data_byte} : idl_w;
        fin_idl  = ((idl_upd != 16'd0) && !idl_upd[15]) ? idl_upd[14:0] : 15'd0;
        fin_hlen = source_is_client ? (lpfhp_pkg::CLIENT_HDR_BASE + {1'b0, fin_idl})
                                    : lpfhp_pkg::SERVER_HDR_LEN;
        fin_bad  = size_w < {16'd0, fin_hlen};
        fin_zero = size_w == {16'd0, fin_hlen};
        fin_rem  = size_w - {16'd0, fin_hlen};
        rem_dec  = rem_reg - 32'd1;
    end

    always_comb begin
        phase_next  = phase_reg;
        fbc_next    = fbc_reg;
        offset_next = offset_reg;
        halted_next = halted_reg;
        start_next  = start_reg;
        size_next   = size_reg;
        key_next    = key_reg;
        ver_next    = ver_reg;
        corr_next   = corr_reg;
        idl_next    = idl_reg;
        rem_next    = rem_reg;
        hlen_next   = hlen_reg;
        outcome     = lpfhp_pkg::OUT_NONE;
        do_finish   = 1'b0;
        res_valid   = 1'b0;
        res         = '0;
        idl_out     = 16'd0;
        pay_out     = 32'd0;

        if (step && halted_reg) begin
            // Drop words until the end of the stream.
            if (last_byte) begin
                phase_next  = lpfhp_pkg::PH_SIZE;
                fbc_next    = 2'd0;
                offset_next = 32'd0;
                halted_next = 1'b0;
            end else begin
                offset_next = offset_reg + 32'd1;
            end
        end else if (step) begin
            if (fresh) begin
                start_next = offset_reg;
                key_next   = 16'd0;
                ver_next   = 16'd0;
                corr_next  = 32'd0;
                hlen_next  = 16'd0;
            end
            size_next = size_w;
            idl_next  = idl_w;
            fbc_next  = fbc_reg + 2'd1;

            case (phase_reg)
                lpfhp_pkg::PH_SIZE: begin
                    size_next = {size_w[23:0], data_byte};
                    if (fbc_next == 2'd0) begin
                        if ((size_next == 32'd0) || size_next[31]) begin
                            outcome = lpfhp_pkg::OUT_BAD;
                        end else begin
                            phase_next = source_is_client ? lpfhp_pkg::PH_KEY
                                                          : lpfhp_pkg::PH_CORR;
                        end
                    end
                end
                lpfhp_pkg::PH_KEY: begin
                    key_next = {key_reg[7:0], data_byte};
                    if (fbc_next == 2'd2) begin
                        fbc_next   = 2'd0;
                        phase_next = lpfhp_pkg::PH_VER;
                    end
                end
                lpfhp_pkg::PH_VER: begin
                    ver_next = {ver_reg[7:0], data_byte};
                    if (fbc_next == 2'd2) begin
                        fbc_next   = 2'd0;
                        phase_next = lpfhp_pkg::PH_CORR;
                    end
                end
                lpfhp_pkg::PH_CORR: begin
                    corr_next = {corr_reg[23:0], data_byte};
                    if (fbc_next == 2'd0) begin
                        if (source_is_client) begin
                            phase_next = lpfhp_pkg::PH_IDLEN;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                end
                lpfhp_pkg::PH_IDLEN: begin
                    idl_next = idl_upd;
                    if (fbc_next == 2'd2) begin
                        fbc_next = 2'd0;
                        if ((idl_upd != 16'd0) && !idl_upd[15]) begin
                            rem_next   = {16'd0, idl_upd};
                            phase_next = lpfhp_pkg::PH_ID;
                        end else begin
                            do_finish = 1'b1;
                        end
                    end
                end
                lpfhp_pkg::PH_ID: begin
                    fbc_next = 2'd0;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) begin
                        do_finish = 1'b1;
                    end
                end
                default: begin
                    // Payload: count down to the frame's last word.
                    fbc_next = 2'd0;
                    rem_next = rem_dec;
                    if (rem_dec == 32'd0) begin
                        outcome = lpfhp_pkg::OUT_VALID;
                    end
                end
            endcase

            if (do_finish) begin
                hlen_next = fin_hlen;
                if (fin_bad) begin
                    outcome = lpfhp_pkg::OUT_BAD;
                end else begin
                    rem_next = fin_rem;
                    if (fin_zero) begin
                        outcome = lpfhp_pkg::OUT_VALID;
                    end else begin
                        phase_next = lpfhp_pkg::PH_PAYLOAD;
                    end
                end
            end

            if ((outcome == lpfhp_pkg::OUT_NONE) && last_byte) begin
                outcome = lpfhp_pkg::OUT_BAD;
            end

            idl_out = (hlen_next > lpfhp_pkg::SERVER_HDR_LEN)
                    ? (hlen_next - lpfhp_pkg::CLIENT_HDR_BASE) : 16'd0;
            pay_out = size_next - {16'd0, hlen_next};

            case (outcome)
                lpfhp_pkg::OUT_VALID: begin
                    res_valid            = 1'b1;
                    res.result_kind      = 1'b0;
                    res.frame_offset     = start_next;
                    res.frame_size       = size_next;
                    res.request_key      = key_next;
                    res.request_version  = ver_next;
                    res.corr_id          = corr_next;
                    res.client_id_length = idl_out[14:0];
                    res.payload_length   = pay_out[30:0];
                    phase_next           = lpfhp_pkg::PH_SIZE;
                    fbc_next             = 2'd0;
                end
                lpfhp_pkg::OUT_BAD: begin
                    res_valid        = 1'b1;
                    res.result_kind  = 1'b1;
                    res.frame_offset = start_next;
                    halted_next      = 1'b1;
                    phase_next       = lpfhp_pkg::PH_SIZE;
                    fbc_next         = 2'd0;
                end
                default: begin
                end
            endcase

            if (last_byte) begin
                phase_next  = lpfhp_pkg::PH_SIZE;
                fbc_next    = 2'd0;
                offset_next = 32'd0;
                halted_next = 1'b0;
            end else begin
                offset_next = offset_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= lpfhp_pkg::PH_SIZE;
            fbc_reg    <= 2'd0;
            offset_reg <= 32'd0;
            halted_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            fbc_reg    <= fbc_next;
            offset_reg <= offset_next;
            halted_reg <= halted_next;
        end
    end

    always_ff @(posedge aclk) begin
        start_reg <= start_next;
        size_reg  <= size_next;
        key_reg   <= key_next;
        ver_reg   <= ver_next;
        corr_reg  <= corr_next;
        idl_reg   <= idl_next;
        rem_reg   <= rem_next;
        hlen_reg  <= hlen_next;
    end

    `LPFHP_ASSERT_NOW(a_halt_parks, aclk, aresetn, halted_reg,
        (phase_reg == lpfhp_pkg::PH_SIZE) && (fbc_reg == 2'd0),
        "halted parser is not parked at a size field")
    `LPFHP_ASSERT_NOW(a_last_reports, aclk, aresetn, step && !halted_reg && last_byte,
        res_valid, "end of stream inside a frame gave no result")
    `LPFHP_ASSERT_NEXT(a_last_restarts, aclk, aresetn, step && last_byte,
        (offset_reg == 32'd0) && !halted_reg, "stream end did not restart the parser")

endmodule

[rtl/core/lpfhp_skid.sv]
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module lpfhp_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpfhp_pkg::result_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lpfhp_pkg::result_t out_data
);

    `include "length_prefixed_frame_header_parser_assert.svh"

    logic               main_valid_reg;
    logic               skid_valid_reg;
    lpfhp_pkg::result_t main_data_reg;
    lpfhp_pkg::result_t skid_data_reg;
    logic               push;
    logic               pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop || !main_valid_reg) begin
            main_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (push) begin
            skid_data_reg <= in_data;
        end
    end

    `LPFHP_ASSERT_NOW(a_skid_behind_main, aclk, aresetn, skid_valid_reg, main_valid_reg,
        "skid entry held while output register is empty")
    `LPFHP_ASSERT_NEXT(a_push_to_skid, aclk, aresetn, main_valid_reg && !pop && push,
        skid_valid_reg, "result pushed into a full output register was lost")
    `LPFHP_ASSERT_NEXT(a_skid_drains, aclk, aresetn, skid_valid_reg && pop,
        main_valid_reg && !skid_valid_reg, "skid entry not moved to output register")

endmodule

[rtl/core/length_prefixed_frame_header_parser.sv]
// Top level of the length-prefixed frame header parser.
`timescale 1ns / 1ps
// Throughput: one byte word per cycle while m_tready is high; the byte's state update is
//   registered in the parser registers.
// A frame's result is registered in the output register, or in the skid stage if that is held.
// s_tready drops only when both result-buffer entries are full.
// Reset (aresetn low, synchronous): parser at a size field, offset 0, not halted, buffer empty,
//   source_is_client set to 1 (client headers).

module length_prefixed_frame_header_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration: source_is_client.
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    // Byte stream in.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // last_byte
    // Frame results out.
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] frame_offset, [63:32] frame_size, [79:64] request_key,
    // [95:80] request_version, [127:96] corr_id, [142:128] client_id_length,
    // [173:143] payload_length, [175:174] zero
    output logic [175:0] m_tdata,
    output logic         m_tuser    // result_kind
);

    logic               source_is_client_reg;
    logic               step;
    logic               res_valid;
    lpfhp_pkg::result_t res;
    lpfhp_pkg::result_t out_res;

    // Hold the mode; the user must write it only while the block is idle; the block does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_is_client_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            source_is_client_reg <= cfg_wr_data;
        end
    end

    // Advance the parser on every accepted word.
    assign step = s_tvalid && s_tready;

    lpfhp_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (step),
        .data_byte        (s_tdata),
        .last_byte        (s_tlast),
        .source_is_client (source_is_client_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    // The buffer's skid stage lets a word be taken while a result waits on m_tready.
    lpfhp_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_ready  (s_tready),
        .in_data   (res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result fields, lowest first.
    assign m_tdata = {2'b00,
                      out_res.payload_length,
                      out_res.client_id_length,
                      out_res.corr_id,
                      out_res.request_version,
                      out_res.request_key,
                      out_res.frame_size,
                      out_res.frame_offset};
    assign m_tuser = out_res.result_kind;

endmodule

[tb/testbench.sv]
// Testbench for the length-prefixed frame header parser: byte stream in, frame results checked.
`timescale 1ns / 1ps

module testbench;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_wr_data = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;    // [7:0] data_byte
    logic         s_tlast = 1'b0;     // last_byte
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // [31:0] frame_offset, [63:32] frame_size, [79:64] request_key,
    // [95:80] request_version, [127:96] corr_id, [142:128] client_id_length,
    // [173:143] payload_length, [175:174] zero
    logic [175:0] m_tdata;
    logic         m_tuser;            // result_kind

    length_prefixed_frame_header_parser uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Idling odds in percent, and a long receiver hold-off on request.
    int send_idle_pct = 28;
    int recv_idle_pct = 82;
    int hold_request = 0;
    int errors = 0;
    int sent_total = 0;

    // Predicted frame results, oldest first.
    lpfhp_pkg::result_t pending_frames[$];
    // Bytes of the frame being composed.
    logic [7:0] frame_bytes[$];

    // Predictor state: mirrors the parser after reset.
    logic              client_mode = 1'b1;
    lpfhp_pkg::phase_t cur_phase = lpfhp_pkg::PH_SIZE;
    logic [1:0]        fld_cnt = 2'd0;
    logic [31:0]       byte_pos = 32'd0;
    logic [31:0]       frm_start = 32'd0;
    logic [31:0]       size_acc = 32'd0;
    logic [15:0]       key_acc = 16'd0;
    logic [15:0]       ver_acc = 16'd0;
    logic [31:0]       corr_acc = 32'd0;
    logic [15:0]       idlen_acc = 16'd0;
    logic [31:0]       left_cnt = 32'd0;
    logic [31:0]       hdr_bytes = 32'd0;
    logic              stopped = 1'b0;

    // Header complete: size it, then decide between done, payload and too large.
    function automatic lpfhp_pkg::outcome_t close_header();
        logic [31:0] id_used;
        id_used = (client_mode && idlen_acc != 16'd0 && !idlen_acc[15]) ?
                  {16'd0, idlen_acc} : 32'd0;
        hdr_bytes = client_mode ? 32'd10 + id_used : 32'd4;
        if (size_acc < hdr_bytes)
            return lpfhp_pkg::OUT_BAD;
        left_cnt = size_acc - hdr_bytes;
        if (left_cnt == 32'd0)
            return lpfhp_pkg::OUT_VALID;
        cur_phase = lpfhp_pkg::PH_PAYLOAD;
        return lpfhp_pkg::OUT_NONE;
    endfunction

    // Advance the parser state by one accepted byte; queue any frame it decides.
    function automatic void parse_byte(input logic [7:0] b, input logic last);
        lpfhp_pkg::outcome_t verdict;
        lpfhp_pkg::result_t  r;
        logic [31:0]         id_out;
        logic [31:0]         pay_out;
        verdict = lpfhp_pkg::OUT_NONE;
        if (stopped) begin
            // Halted: drop bytes until the stream ends.
            if (last) begin
                cur_phase = lpfhp_pkg::PH_SIZE;
                fld_cnt = 2'd0;
                byte_pos = 32'd0;
                stopped = 1'b0;
            end else begin
                byte_pos = byte_pos + 32'd1;
            end
            return;
        end
        if (cur_phase == lpfhp_pkg::PH_SIZE && fld_cnt == 2'd0) begin
            frm_start = byte_pos;
            size_acc = 32'd0;
            key_acc = 16'd0;
            ver_acc = 16'd0;
            corr_acc = 32'd0;
            idlen_acc = 16'd0;
            hdr_bytes = 32'd0;
        end
        fld_cnt = fld_cnt + 2'd1;
        case (cur_phase)
            lpfhp_pkg::PH_SIZE: begin
                size_acc = {size_acc[23:0], b};
                if (fld_cnt == 2'd0) begin
                    if (size_acc == 32'd0 || size_acc[31])
                        verdict = lpfhp_pkg::OUT_BAD;
                    else
                        cur_phase = client_mode ? lpfhp_pkg::PH_KEY : lpfhp_pkg::PH_CORR;
                end
            end
            lpfhp_pkg::PH_KEY: begin
                key_acc = {key_acc[7:0], b};
                if (fld_cnt == 2'd2) begin
                    fld_cnt = 2'd0;
                    cur_phase = lpfhp_pkg::PH_VER;
                end
            end
            lpfhp_pkg::PH_VER: begin
                ver_acc = {ver_acc[7:0], b};
                if (fld_cnt == 2'd2) begin
                    fld_cnt = 2'd0;
                    cur_phase = lpfhp_pkg::PH_CORR;
                end
            end
            lpfhp_pkg::PH_CORR: begin
                corr_acc = {corr_acc[23:0], b};
                if (fld_cnt == 2'd0) begin
                    if (client_mode)
                        cur_phase = lpfhp_pkg::PH_IDLEN;
                    else
                        verdict = close_header();
                end
            end
            lpfhp_pkg::PH_IDLEN: begin
                idlen_acc = {idlen_acc[7:0], b};
                if (fld_cnt == 2'd2) begin
                    fld_cnt = 2'd0;
                    if (idlen_acc != 16'd0 && !idlen_acc[15]) begin
                        left_cnt = {16'd0, idlen_acc};
                        cur_phase = lpfhp_pkg::PH_ID;
                    end else begin
                        verdict = close_header();
                    end
                end
            end
            lpfhp_pkg::PH_ID: begin
                fld_cnt = 2'd0;
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0)
                    verdict = close_header();
            end
            default: begin
                fld_cnt = 2'd0;
                left_cnt = left_cnt - 32'd1;
                if (left_cnt == 32'd0)
                    verdict = lpfhp_pkg::OUT_VALID;
            end
        endcase

        // Stream ends on a byte that decided nothing: the frame is cut short.
        if (verdict == lpfhp_pkg::OUT_NONE && last)
            verdict = lpfhp_pkg::OUT_BAD;

        if (verdict != lpfhp_pkg::OUT_NONE) begin
            r = '0;
            r.frame_offset = frm_start;
            if (verdict == lpfhp_pkg::OUT_VALID) begin
                id_out = (hdr_bytes > 32'd4) ? hdr_bytes - 32'd10 : 32'd0;
                pay_out = size_acc - hdr_bytes;
                r.result_kind = 1'b0;
                r.frame_size = size_acc;
                r.request_key = key_acc;
                r.request_version = ver_acc;
                r.corr_id = corr_acc;
                r.client_id_length = id_out[14:0];
                r.payload_length = pay_out[30:0];
            end else begin
                r.result_kind = 1'b1;
                stopped = 1'b1;
            end
            pending_frames.insert(pending_frames.size(), r);
            cur_phase = lpfhp_pkg::PH_SIZE;
            fld_cnt = 2'd0;
        end

        if (last) begin
            cur_phase = lpfhp_pkg::PH_SIZE;
            fld_cnt = 2'd0;
            byte_pos = 32'd0;
            stopped = 1'b0;
        end else begin
            byte_pos = byte_pos + 32'd1;
        end
    endfunction

    // Offer one byte word, with a random gap first; predict once it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        parse_byte(b, last);
        sent_total++;
    endtask

    // Drop valid and hold until every predicted result has come out.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_frames.size() != 0)
            @(posedge aclk);
        // Let a frame still in the register stage settle.
        repeat (4) @(posedge aclk);
    endtask

    // Write source_is_client once the block is idle.
    task automatic set_source_mode(input logic v);
        wait_drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        client_mode = v;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic void push_be(input logic [31:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            frame_bytes.insert(frame_bytes.size(), v[8*i +: 8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++)
            frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(255)));
    endfunction

    // Lay out a header in the layout of the current mode.
    function automatic void compose_header(input logic [31:0] size, input logic [15:0] key,
                                           input logic [15:0] ver, input logic [31:0] corr,
                                           input logic [15:0] idlen);
        push_be(size, 4);
        if (client_mode) begin
            push_be(32'(key), 2);
            push_be(32'(ver), 2);
            push_be(corr, 4);
            push_be(32'(idlen), 2);
        end else begin
            push_be(corr, 4);
        end
    endfunction

    // Send the composed bytes, marking the final one as the stream's last if asked.
    task automatic flush_bytes(input logic end_stream);
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(frame_bytes[i], end_stream && (i == n - 1));
        frame_bytes.delete();
    endtask

    // Compose one well-formed frame with random content.
    task automatic add_good_frame();
        logic [15:0] idl;
        int          used;
        int          pay;
        int          pick;
        pick = $urandom_range(9);
        if (pick < 4)
            idl = 16'd0;
        else if (pick < 6)
            idl = 16'h8000 | 16'($urandom_range(16'h7FFF));
        else
            idl = 16'($urandom_range(1, 6));
        used = (client_mode && idl != 16'd0 && !idl[15]) ? int'(idl) : 0;
        pay = $urandom_range(0, 10);
        compose_header(32'(client_mode ? 10 + used + pay : 4 + pay),
                       16'($urandom), 16'($urandom), $urandom, idl);
        push_random(used + pay);
    endtask

    // One stream: some good frames, then a clean end or a broken tail.
    task automatic run_stream();
        int          n;
        int          pick;
        int          cut;
        logic [15:0] idl;
        n = $urandom_range(0, 5);
        repeat (n) begin
            add_good_frame();
            flush_bytes(1'b0);
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
            add_good_frame();
            flush_bytes(1'b1);
        end else if (pick < 52) begin
            // Zero or negative size, then junk until the end.
            push_be($urandom_range(1) ? 32'd0 : (32'h8000_0000 | $urandom), 4);
            push_random($urandom_range(0, 3));
            flush_bytes(1'b1);
        end else if (pick < 64) begin
            // Size smaller than the header.
            idl = 16'($urandom_range(0, 4));
            if (client_mode) begin
                compose_header($urandom_range(1, 9 + int'(idl)), 16'($urandom),
                               16'($urandom), $urandom, idl);
                push_random(int'(idl));
            end else begin
                compose_header($urandom_range(1, 3), 16'd0, 16'd0, $urandom, 16'd0);
            end
            push_random($urandom_range(0, 3));
            flush_bytes(1'b1);
        end else if (pick < 80) begin
            // Good frame cut short by the stream's end.
            add_good_frame();
            cut = $urandom_range(1, frame_bytes.size() - 1);
            repeat (cut) void'(frame_bytes.pop_back());
            flush_bytes(1'b1);
        end else if (pick < 90) begin
            // Large size: never completes, the stream ends inside it.
            compose_header(($urandom & 32'h7FFF_FFFF) | 32'h0001_0000, 16'($urandom),
                           16'($urandom), $urandom, 16'($urandom));
            push_random($urandom_range(0, 8));
            flush_bytes(1'b1);
        end else begin
            push_random($urandom_range(1, 6));
            flush_bytes(1'b1);
        end
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial begin : rx_side
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        end
    endtask

    lpfhp_pkg::result_t want_r;
    lpfhp_pkg::result_t got_r;

    // Compare each result word taken with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_r.result_kind = m_tuser;
            got_r.frame_offset = m_tdata[31:0];
            got_r.frame_size = m_tdata[63:32];
            got_r.request_key = m_tdata[79:64];
            got_r.request_version = m_tdata[95:80];
            got_r.corr_id = m_tdata[127:96];
            got_r.client_id_length = m_tdata[142:128];
            got_r.payload_length = m_tdata[173:143];
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual kind %0b offset %h",
                         $time, got_r.result_kind, got_r.frame_offset);
            end else begin
                want_r = pending_frames.pop_front();
                check_field("result_kind", 32'(want_r.result_kind),
                            32'(got_r.result_kind));
                check_field("frame_offset", want_r.frame_offset, got_r.frame_offset);
                check_field("frame_size", want_r.frame_size, got_r.frame_size);
                check_field("request_key", 32'(want_r.request_key),
                            32'(got_r.request_key));
                check_field("request_version", 32'(want_r.request_version),
                            32'(got_r.request_version));
                check_field("corr_id", want_r.corr_id, got_r.corr_id);
                check_field("client_id_length", 32'(want_r.client_id_length),
                            32'(got_r.client_id_length));
                check_field("payload_length", 32'(want_r.payload_length),
                            32'(got_r.payload_length));
            end
        end
    end

    task automatic test_client_headers();
        set_source_mode(1'b1);
        // Header only, key, version and correlation id at their top values.
        compose_header(32'd10, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'd0);
        flush_bytes(1'b0);
        // Negative id length counts as none.
        compose_header(32'd13, 16'd0, 16'd0, 32'd0, 16'h8000);
        push_random(3);
        flush_bytes(1'b0);
        // Id bytes and payload; the stream ends on the completing byte.
        compose_header(32'd13, 16'($urandom), 16'($urandom), $urandom, 16'd2);
        push_random(3);
        flush_bytes(1'b1);
    endtask

    task automatic test_bad_size();
        push_be(32'd0, 4);
        push_random(2);
        flush_bytes(1'b1);
        push_be(32'hFFFF_FFFF, 4);
        flush_bytes(1'b1);
    endtask

    task automatic test_header_too_large();
        compose_header(32'd9, 16'($urandom), 16'($urandom), $urandom, 16'd0);
        push_random(1);
        flush_bytes(1'b1);
        // Found only once the id bytes are in.
        compose_header(32'd12, 16'($urandom), 16'($urandom), $urandom, 16'd5);
        push_random(5);
        flush_bytes(1'b1);
    endtask

    task automatic test_stream_cut();
        compose_header(32'h7FFF_FFFF, 16'($urandom), 16'($urandom), $urandom, 16'd3);
        push_random(5);
        flush_bytes(1'b1);
        // Ends inside the size field, then a one-byte stream.
        push_random(2);
        flush_bytes(1'b1);
        push_random(1);
        flush_bytes(1'b1);
    endtask

    task automatic test_server_headers();
        set_source_mode(1'b0);
        compose_header(32'd4, 16'd0, 16'd0, $urandom, 16'd0);
        flush_bytes(1'b0);
        compose_header(32'd6, 16'd0, 16'd0, $urandom, 16'd0);
        push_random(2);
        flush_bytes(1'b0);
        compose_header(32'd1, 16'd0, 16'd0, $urandom, 16'd0);
        flush_bytes(1'b1);
    endtask

    task automatic test_mode_switch();
        // Start a server frame, switch to client headers inside the correlation id.
        push_be(32'd20, 4);
        push_random(2);
        flush_bytes(1'b0);
        set_source_mode(1'b1);
        push_random(20);
        flush_bytes(1'b1);
    endtask

    task automatic test_back_pressure();
        set_source_mode(1'b0);
        send_idle_pct = 0;
        // Hold the receiver off while short frames keep coming, so the input stalls.
        hold_request = 300;
        repeat (30) compose_header(32'd4, 16'd0, 16'd0, $urandom, 16'd0);
        flush_bytes(1'b1);
        wait_drain();
        send_idle_pct = 28;
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    send_idle_pct = 28;
                    recv_idle_pct = 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct = 28;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_end = sent_total + 230;
            while (sent_total < phase_end) begin
                if ($urandom_range(3) == 0)
                    set_source_mode(1'($urandom_range(1)));
                run_stream();
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_client_headers();
        test_bad_size();
        test_header_too_large();
        test_stream_cut();
        test_server_headers();
        test_mode_switch();
        test_back_pressure();
        test_random_traffic();

        wait_drain();
        repeat (20) @(posedge aclk);
        if (pending_frames.size() != 0) begin
            errors++;
            $display("%0t: missing results: expected %0d more, actual none",
                     $time, pending_frames.size());
        end
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(5_000_000);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
